// ===== hw/rtl/pq3_pkg.sv =====
// Shared types and constants for the three-class strict priority queue.
// No dependencies; every module of the block imports this package.
package pq3_pkg;

  localparam int CAPACITY    = 16;
  localparam int NUM_CLASSES = 3;

  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * CAPACITY);

  localparam int TICKET_W = 16;
  localparam int AGE_W    = 7;

  localparam logic [1:0] CLS_ELDERLY = 2'd0;
  localparam logic [1:0] CLS_HEALTH  = 2'd1;
  localparam logic [1:0] CLS_GENERAL = 2'd2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ_OK    = 2'd0,
    ST_ENQ_FULL  = 2'd1,
    ST_DEQ_OK    = 2'd2,
    ST_DEQ_EMPTY = 2'd3
  } status_t;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [AGE_W-1:0]    age;
  } entry_t;

  // Registered request as seen by the control logic
  typedef struct packed {
    logic       valid;
    logic       op;
    logic [1:0] cls;
  } req_t;

  // Slot memory write and read access
  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } mem_req_t;

  // Result information that travels beside the memory read
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [1:0] cls;
  } meta_t;

endpackage

// ===== hw/rtl/pq3_store.sv =====
// Slot memory: one ring of CAPACITY entries per class, registered read.
// Depends on pq3_pkg.
module pq3_store (
  input  logic              clk,
  input  pq3_pkg::mem_req_t mem,
  output pq3_pkg::entry_t   rd_data
);
  import pq3_pkg::*;

  entry_t slots [NUM_CLASSES * CAPACITY];

  always_ff @(posedge clk) begin
    if (mem.wr_en) begin
      slots[mem.wr_addr] <= mem.wr_data;
    end
    if (mem.rd_en) begin
      rd_data <= slots[mem.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pq3_ctrl.sv =====
// Per-class ring pointers, counts and class selection for the queue.
// Depends on pq3_pkg; drives the slot memory in pq3_store.
module pq3_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  pq3_pkg::req_t     req,
  input  pq3_pkg::entry_t   req_data,
  output pq3_pkg::mem_req_t mem,
  output pq3_pkg::meta_t    meta
);
  import pq3_pkg::*;

  ptr_t heads [NUM_CLASSES];
  ptr_t tails [NUM_CLASSES];
  cnt_t counts [NUM_CLASSES];
  cnt_t total;

  ptr_t heads_next [NUM_CLASSES];
  ptr_t tails_next [NUM_CLASSES];
  cnt_t counts_next [NUM_CLASSES];
  cnt_t total_next;

  logic [1:0] enq_cls;
  logic [1:0] deq_cls;
  logic       any_held;
  logic       full;

  function automatic ptr_t ring_next(input ptr_t p);
    cnt_t n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= CNT_W'(CAPACITY)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic addr_t slot_addr(input logic [1:0] c, input ptr_t p);
    return ADDR_W'(c) * ADDR_W'(CAPACITY) + ADDR_W'(p);
  endfunction

  // Class code three is stored as general
  assign enq_cls  = req.cls[1] ? CLS_GENERAL : req.cls;
  assign full     = (total >= CNT_W'(CAPACITY));
  assign any_held = (counts[0] != '0) || (counts[1] != '0) || (counts[2] != '0);

  always_comb begin
    if (counts[0] != '0) begin
      deq_cls = CLS_ELDERLY;
    end else if (counts[1] != '0) begin
      deq_cls = CLS_HEALTH;
    end else begin
      deq_cls = CLS_GENERAL;
    end
  end

  always_comb begin
    heads_next  = heads;
    tails_next  = tails;
    counts_next = counts;
    total_next  = total;
    mem.wr_en   = 1'b0;
    mem.wr_addr = slot_addr(enq_cls, tails[enq_cls]);
    mem.wr_data = req_data;
    mem.rd_en   = 1'b0;
    mem.rd_addr = slot_addr(deq_cls, heads[deq_cls]);
    meta.valid  = req.valid;
    meta.status = ST_ENQ_OK;
    meta.cls    = '0;
    if (req.valid) begin
      if (req.op == OP_ENQ) begin
        if (full) begin
          meta.status = ST_ENQ_FULL;
        end else begin
          mem.wr_en            = 1'b1;
          tails_next[enq_cls]  = ring_next(tails[enq_cls]);
          counts_next[enq_cls] = counts[enq_cls] + CNT_W'(1);
          total_next           = total + CNT_W'(1);
          meta.status          = ST_ENQ_OK;
        end
      end else begin
        if (any_held) begin
          mem.rd_en            = 1'b1;
          heads_next[deq_cls]  = ring_next(heads[deq_cls]);
          counts_next[deq_cls] = counts[deq_cls] - CNT_W'(1);
          total_next           = total - CNT_W'(1);
          meta.status          = ST_DEQ_OK;
          meta.cls             = deq_cls;
        end else begin
          meta.status = ST_DEQ_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
      total <= '0;
    end else begin
      heads  <= heads_next;
      tails  <= tails_next;
      counts <= counts_next;
      total  <= total_next;
    end
  end

endmodule

// ===== hw/rtl/three_class_strict_priority_queue.sv =====
// Top level of the three-class strict priority queue.
// Depends on pq3_pkg, pq3_ctrl and pq3_store.
//
// Usage:
//   Raise start with op and the entry fields; the item is taken at a rising
//   edge where start is high and busy is low. op enqueue stores ticket and
//   age at the tail of priority_class (code three counts as general); op
//   dequeue removes the oldest entry of the highest class that holds one.
//   Each item gives one result: done is high for exactly one cycle with
//   status, out_class, out_ticket and out_age; the last three are zero
//   unless an entry was dequeued.
//   Each item passes through the input register, then the slot memory read
//   register, before its result appears. Throughput: one item every cycle;
//   pointer and count updates are computed between those registers and stored
//   with the slot memory read, so back-to-back items see each other's effect.
//   Capacity is CAPACITY entries over all classes; an enqueue when full is
//   reported as rejected and changes nothing.
//   Reset empties every class at once; busy is high while rst is applied and
//   stays high until the busy register samples rst low, so no item is taken
//   before busy has fallen. Results cannot be held off by the receiver.
module three_class_strict_priority_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [1:0]                     priority_class,
  input  logic [pq3_pkg::TICKET_W-1:0]   ticket,
  input  logic [pq3_pkg::AGE_W-1:0]      age_years,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [1:0]                     out_class,
  output logic [pq3_pkg::TICKET_W-1:0]   out_ticket,
  output logic [pq3_pkg::AGE_W-1:0]      out_age
);
  import pq3_pkg::*;

  logic     accept;
  req_t     req;
  entry_t   req_data;
  mem_req_t mem;
  meta_t    meta;
  meta_t    meta_q;
  entry_t   rd_data;
  logic     deq_ok;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= accept;
    end
    if (accept) begin
      req.op          <= op;
      req.cls         <= priority_class;
      req_data.ticket <= ticket;
      req_data.age    <= age_years;
    end
  end

  pq3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_data (req_data),
    .mem      (mem),
    .meta     (meta)
  );

  pq3_store u_store (
    .clk     (clk),
    .mem     (mem),
    .rd_data (rd_data)
  );

  // Result register, aligned with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_q.valid <= 1'b0;
    end else begin
      meta_q.valid <= meta.valid;
    end
    meta_q.status <= meta.status;
    meta_q.cls    <= meta.cls;
  end

  assign deq_ok     = (meta_q.status == ST_DEQ_OK);
  assign done       = meta_q.valid;
  assign status     = meta_q.status;
  assign out_class  = deq_ok ? meta_q.cls : '0;
  assign out_ticket = deq_ok ? rd_data.ticket : '0;
  assign out_age    = deq_ok ? rd_data.age : '0;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted item gave no result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without an accepted item");

  a_deq_class: assert property (@(posedge clk) disable iff (rst)
    (done && deq_ok) |-> (out_class != 2'd3))
    else $error("dequeued entry carries an invalid class");

endmodule

// ===== bench/tb_three_class_strict_priority_queue.sv =====
// Self-checking bench for the three-class strict priority queue: random and directed
// enqueue/dequeue items are checked against a ring-per-class model kept in the bench.
// Depends on pq3_pkg and three_class_strict_priority_queue.
module tb_three_class_strict_priority_queue;
  import pq3_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    bit                  drain_first;
    logic                op;
    logic [1:0]          cls;
    logic [TICKET_W-1:0] ticket;
    logic [AGE_W-1:0]    age;
  } request_t;

  typedef struct {
    status_t             status;
    logic [1:0]          cls;
    logic [TICKET_W-1:0] ticket;
    logic [AGE_W-1:0]    age;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                op = OP_ENQ;
  logic [1:0]          priority_class = CLS_ELDERLY;
  logic [TICKET_W-1:0] ticket = '0;
  logic [AGE_W-1:0]    age_years = '0;
  logic                busy;
  logic                done;
  logic [1:0]          status;
  logic [1:0]          out_class;
  logic [TICKET_W-1:0] out_ticket;
  logic [AGE_W-1:0]    out_age;

  three_class_strict_priority_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .priority_class(priority_class), .ticket(ticket), .age_years(age_years),
    .done(done), .status(status), .out_class(out_class),
    .out_ticket(out_ticket), .out_age(out_age)
  );

  // Queue model: one ring per class, as many slots per ring as the whole capacity
  entry_t      slot_ring [NUM_CLASSES][CAPACITY];
  int          ring_head [NUM_CLASSES];
  int          ring_tail [NUM_CLASSES];
  int          ring_fill [NUM_CLASSES];
  int          held_total;

  request_t    pending[$];
  outcome_t    awaited[$];
  request_t    nxt;
  outcome_t    want;
  logic        item_taken = 1'b0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned faults = 0;

  function automatic outcome_t serve_request(logic rop, logic [1:0] rcls,
                                             logic [TICKET_W-1:0] rticket,
                                             logic [AGE_W-1:0] rage);
    outcome_t res;
    int       k;
    bit       found;
    res.status = ST_DEQ_EMPTY;
    res.cls    = CLS_ELDERLY;
    res.ticket = '0;
    res.age    = '0;
    found      = 1'b0;
    if (rop == OP_ENQ) begin
      // fold class code three into general
      k = (rcls == 2'd3) ? int'(CLS_GENERAL) : int'(rcls);
      if (held_total >= CAPACITY) begin
        res.status = ST_ENQ_FULL;
      end else begin
        slot_ring[k][ring_tail[k]].ticket = rticket;
        slot_ring[k][ring_tail[k]].age    = rage;
        ring_tail[k] = (ring_tail[k] + 1) % CAPACITY;
        ring_fill[k]++;
        held_total++;
        res.status = ST_ENQ_OK;
      end
    end else begin
      for (k = 0; k < NUM_CLASSES; k++) begin
        if (!found && ring_fill[k] != 0) begin
          res.status = ST_DEQ_OK;
          res.cls    = k[1:0];
          res.ticket = slot_ring[k][ring_head[k]].ticket;
          res.age    = slot_ring[k][ring_head[k]].age;
          ring_head[k] = (ring_head[k] + 1) % CAPACITY;
          ring_fill[k]--;
          held_total--;
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic add_item(bit drain, logic rop, logic [1:0] rcls,
                          logic [TICKET_W-1:0] rticket, logic [AGE_W-1:0] rage);
    request_t r;
    r.drain_first = drain;
    r.op          = rop;
    r.cls         = rcls;
    r.ticket      = rticket;
    r.age         = rage;
    pending.push_back(r);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Driver: present the next item once the current one has been taken
  always @(negedge clk) begin
    if (!rst && (!start || item_taken)) begin
      if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].drain_first && awaited.size() != 0) begin
        start <= 1'b0;
      end else if ((sent_count < 600 || sent_count >= 1000) && $urandom_range(99) < 13) begin
        start <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        start          <= 1'b1;
        op             <= nxt.op;
        priority_class <= nxt.cls;
        ticket         <= nxt.ticket;
        age_years      <= nxt.age;
        sent_count++;
      end
    end
  end

  // Monitor: predict on acceptance, check each result against the oldest expectation
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (start && !busy)
        awaited.push_back(serve_request(op, priority_class, ticket, age_years));
      if (done) begin
        if (awaited.size() == 0) begin
          $error("result with no item outstanding: status %0d", status);
          faults++;
        end else begin
          want = awaited.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            faults++;
          end
          if (out_class !== want.cls) begin
            $error("out_class: expected %0d, actual %0d", want.cls, out_class);
            faults++;
          end
          if (out_ticket !== want.ticket) begin
            $error("out_ticket: expected %0h, actual %0h", want.ticket, out_ticket);
            faults++;
          end
          if (out_age !== want.age) begin
            $error("out_age: expected %0d, actual %0d", want.age, out_age);
            faults++;
          end
        end
      end
    end
  end

  initial begin
    int   made;
    int   mode;
    int   burst;
    int   enq_pct;
    logic is_enq;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      ring_head[k] = 0;
      ring_tail[k] = 0;
      ring_fill[k] = 0;
    end
    held_total = 0;

    // Directed: empty dequeue with stray fields, class code three, extremes, order
    add_item(1'b0, OP_DEQ, 2'd3, 16'hFFFF, 7'h7F);
    add_item(1'b0, OP_ENQ, 2'd3, 16'hFFFF, 7'h7F);
    add_item(1'b0, OP_ENQ, CLS_GENERAL, 16'h0000, 7'd0);
    add_item(1'b0, OP_ENQ, CLS_HEALTH, 16'h1234, 7'd1);
    add_item(1'b0, OP_ENQ, CLS_ELDERLY, 16'h8000, 7'd64);
    add_item(1'b0, OP_ENQ, CLS_HEALTH, 16'h0001, 7'd127);
    add_item(1'b0, OP_DEQ, CLS_GENERAL, 16'hA5A5, 7'd5);
    add_item(1'b0, OP_DEQ, CLS_ELDERLY, 16'h0000, 7'd0);
    add_item(1'b0, OP_ENQ, CLS_ELDERLY, 16'h7FFF, 7'd99);
    add_item(1'b0, OP_DEQ, CLS_ELDERLY, 16'h0000, 7'd0);
    add_item(1'b0, OP_DEQ, CLS_ELDERLY, 16'h0000, 7'd0);
    add_item(1'b0, OP_DEQ, CLS_ELDERLY, 16'h0000, 7'd0);
    add_item(1'b0, OP_DEQ, CLS_ELDERLY, 16'h0000, 7'd0);
    add_item(1'b0, OP_DEQ, 2'd3, 16'hFFFF, 7'h7F);

    // Random bursts that lean towards filling, draining or neither
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(10, 60);
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int n = 0; n < burst; n++) begin
        is_enq = ($urandom_range(99) < enq_pct);
        add_item((made == 0) || (n == 0 && $urandom_range(7) == 0),
                 is_enq ? OP_ENQ : OP_DEQ, 2'($urandom_range(3)),
                 TICKET_W'($urandom), AGE_W'($urandom));
        made++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (faults == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
